// ----- sv/scba_pkg.sv -----
// Package: shared types and constants of the size-class block allocator.
`timescale 1ns / 1ps
package scba_pkg;

  localparam int unsigned HeaderBytes = 4;
  localparam logic [15:0] NoNode      = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RECLAIM = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OUT_OF_MEM  = 2'd1,
    ST_DOUBLE_FREE = 2'd2,
    ST_IGNORED     = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_A_HEAD,
    S_A_HDR,
    S_A_LINK,
    S_A_CARVE,
    S_F_CHK,
    S_F_HDR,
    S_P_HDR,
    S_P_LINK,
    S_R_TEST,
    S_R_HDR1,
    S_R_HDR2,
    S_RM_START,
    S_RM_TEST,
    S_RM_LINK,
    S_RM_END,
    S_DONE
  } fsm_e;

endpackage

// ----- sv/scba_if.sv -----
// Interfaces: request and response channels of the allocator.
`timescale 1ns / 1ps
interface scba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] request_bytes;
  logic [15:0] payload_address;
  modport source (output valid, opcode, request_bytes, payload_address, input ready);
  modport sink (input valid, opcode, request_bytes, payload_address, output ready);
endinterface

interface scba_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_address_res;
  logic [1:0]  status;
  logic [16:0] used_bytes;
  logic [16:0] free_bytes;
  modport source (output valid, payload_address_res, status, used_bytes, free_bytes,
                  input ready);
  modport sink (input valid, payload_address_res, status, used_bytes, free_bytes,
                output ready);
endinterface

// ----- sv/scba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module scba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- sv/size_class_block_allocator.sv -----
// Top level: size-class block allocator with free lists and reclaim.
//
//   channel   | dir | handshake              | beat contents
//   ----------+-----+------------------------+------------------------------------------
//   req_i     | in  | valid/ready            | opcode, request_bytes, payload_address
//   rsp_o     | out | valid/ready            | payload_address_res, status, used/free
//   APB       | in  | psel/penable/pwrite    | pool_limit_bytes at byte address 0
//
// One request beat is handled at a time by a sequencer around a single pool RAM with
// one write and one registered read port. Reclaim reads the header of each block walked,
// and that of the next block too where the first is free; a merge unlinks both blocks
// from their lists, one node visited at a time, before the joined block is put on its
// list. Reset clears the list heads to empty, the high-water mark and the free total;
// the pool needs no clearing pass. A finished result sits in the output register, and
// the next request beat is taken while it waits; a stalled result only holds the
// sequencer at its final step.
`timescale 1ns / 1ps
module size_class_block_allocator
  import scba_pkg::*;
#(
  parameter int unsigned POOL_BYTES  = 65536,
  parameter int unsigned CLASS_COUNT = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scba_req_if.sink    req_i,
  scba_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PoolWords = POOL_BYTES / 4;
  localparam int unsigned AW        = $clog2(PoolWords);
  localparam int unsigned LW        = $clog2(CLASS_COUNT + 1);
  localparam logic [16:0] PoolLim   = 17'(POOL_BYTES);
  localparam logic [LW-1:0] MiscId  = LW'(CLASS_COUNT);

  // Word index of a header; the link word follows it.
  function automatic logic [AW-1:0] word_of(input logic [17:0] a);
    return a[AW+1:2];
  endfunction

  // List that holds blocks of a given payload size: a class or the misc list.
  function automatic logic [LW-1:0] list_of(input logic [15:0] sz);
    logic [LW-1:0] id;
    id = MiscId;
    for (int i = 0; i < CLASS_COUNT; i++) begin
      if ({1'b0, sz} == (17'd8 << i)) id = LW'(i);
    end
    return id;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [16:0] limit_q, limit_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {15'd0, limit_q} : 32'd0;
  assign limit_d = cfg_wr ? pwdata[16:0] : limit_q;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fsm_e         st_q, st_d;
  logic [15:0]  heads_q [CLASS_COUNT+1];
  logic [15:0]  heads_d [CLASS_COUNT+1];
  logic [16:0]  hw_q, hw_d;
  logic [16:0]  ft_q, ft_d;
  op_e          op_q, op_d;
  logic [16:0]  want_q, want_d;
  logic [LW-1:0] lid_q, lid_d;
  logic         cls_q, cls_d;
  logic [15:0]  addr_q, addr_d;
  logic [15:0]  cur_q, cur_d;
  logic [15:0]  size_q, size_d;
  logic [17:0]  pos_q, pos_d;
  logic [17:0]  nx_q, nx_d;
  logic [15:0]  sp_q, sp_d;
  logic [15:0]  sn_q, sn_d;
  logic [15:0]  prev_q, prev_d;
  logic         prev_v_q, prev_v_d;
  logic [AW:0]  cnt_q, cnt_d;
  logic         phase_q, phase_d;
  logic [15:0]  target_q, target_d;
  logic [15:0]  res_q, res_d;
  status_e      stat_q, stat_d;

  logic         out_v_q, out_v_d;
  logic [15:0]  out_addr_q, out_addr_d;
  status_e      out_stat_q, out_stat_d;
  logic [16:0]  out_used_q, out_used_d;
  logic [16:0]  out_free_q, out_free_d;

  // RAM port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  scba_ram #(.WIDTH(32), .DEPTH(PoolWords)) u_pool (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Shared decode
  // ---------------------------------------------------------------------------
  logic          accept, can_load;
  logic [16:0]   req8, in_want, lim;
  logic [LW-1:0] in_lid;
  logic          in_cls;
  logic [15:0]   head_sel, rd_size;
  logic          rd_free, a_ok, carve_oom, f_bad, r_go2, r_merge, rm_hit, rm_stop;
  logic [17:0]   carve_end, r_nxt, r_end2;

  assign accept   = req_i.valid && req_i.ready;
  assign can_load = !out_v_q || rsp_o.ready;
  assign lim      = (limit_q < PoolLim) ? limit_q : PoolLim;

  // Requests below 8 go up to 8, then to the smallest class that fits; above the
  // largest class the size is rounded to a multiple of the header size.
  always_comb begin
    req8    = (req_i.request_bytes < 16'd8) ? 17'd8 : {1'b0, req_i.request_bytes};
    in_cls  = 1'b0;
    in_lid  = MiscId;
    in_want = (req8 + 17'd3) & ~17'd3;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (req8 <= (17'd8 << i)) begin
        in_cls  = 1'b1;
        in_lid  = LW'(i);
        in_want = 17'd8 << i;
      end
    end
  end

  assign head_sel  = heads_q[lid_q];
  assign rd_size   = ram_rdata[15:0];
  assign rd_free   = ram_rdata[16];
  assign a_ok      = cls_q || ({1'b0, rd_size} >= want_q);
  assign carve_end = {1'b0, hw_q} + 18'd4 + {1'b0, want_q};
  assign carve_oom = carve_end > {1'b0, lim};
  assign f_bad     = (addr_q < 16'd4) || (addr_q[1:0] != 2'd0) ||
                     ({1'b0, addr_q} - 17'd4 >= hw_q);
  assign r_nxt     = pos_q + 18'd4 + {2'b0, rd_size};
  assign r_go2     = rd_free && (r_nxt < {1'b0, hw_q});
  assign r_end2    = nx_q + 18'd4 + {2'b0, rd_size};
  assign r_merge   = rd_free && (r_end2 <= {1'b0, hw_q});
  assign rm_hit    = cur_q == target_q;
  assign rm_stop   = (cur_q == NoNode) || (cnt_q == (AW+1)'(PoolWords));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(req_i.opcode))
            OP_ALLOC:   st_d = S_A_HEAD;
            OP_FREE:    st_d = S_F_CHK;
            OP_RECLAIM: st_d = S_R_TEST;
            default:    st_d = S_DONE;
          endcase
        end
      end
      S_A_HEAD:   st_d = (head_sel != NoNode) ? S_A_HDR : S_A_CARVE;
      S_A_HDR:    st_d = a_ok ? S_A_LINK : S_A_CARVE;
      S_A_LINK:   st_d = S_DONE;
      S_A_CARVE:  st_d = S_DONE;
      S_F_CHK:    st_d = f_bad ? S_DONE : S_F_HDR;
      S_F_HDR:    st_d = rd_free ? S_DONE : S_P_HDR;
      S_P_HDR:    st_d = S_P_LINK;
      S_P_LINK:   st_d = (op_q == OP_FREE) ? S_DONE : S_R_TEST;
      S_R_TEST:   st_d = (pos_q >= {1'b0, hw_q}) ? S_DONE : S_R_HDR1;
      S_R_HDR1:   st_d = r_go2 ? S_R_HDR2 : S_R_TEST;
      S_R_HDR2:   st_d = r_merge ? S_RM_START : S_R_TEST;
      S_RM_START: st_d = S_RM_TEST;
      S_RM_TEST:  st_d = rm_stop ? S_RM_END : S_RM_LINK;
      S_RM_LINK:  st_d = rm_hit ? S_RM_END : S_RM_TEST;
      S_RM_END:   st_d = phase_q ? S_P_HDR : S_RM_START;
      S_DONE:     st_d = can_load ? S_IDLE : S_DONE;
      default:    st_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and RAM control
  // ---------------------------------------------------------------------------
  always_comb begin
    heads_d    = heads_q;
    hw_d       = hw_q;
    ft_d       = ft_q;
    op_d       = op_q;
    want_d     = want_q;
    lid_d      = lid_q;
    cls_d      = cls_q;
    addr_d     = addr_q;
    cur_d      = cur_q;
    size_d     = size_q;
    pos_d      = pos_q;
    nx_d       = nx_q;
    sp_d       = sp_q;
    sn_d       = sn_q;
    prev_d     = prev_q;
    prev_v_d   = prev_v_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    target_d   = target_q;
    res_d      = res_q;
    stat_d     = stat_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    out_addr_d = out_addr_q;
    out_stat_d = out_stat_q;
    out_used_d = out_used_q;
    out_free_d = out_free_q;
    out_v_d    = rsp_o.ready ? 1'b0 : out_v_q;

    case (st_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(req_i.opcode);
          want_d = in_want;
          lid_d  = in_lid;
          cls_d  = in_cls;
          addr_d = req_i.payload_address;
          pos_d  = '0;
          res_d  = '0;
          stat_d = ST_OK;
        end
      end
      S_A_HEAD: begin
        cur_d     = head_sel;
        ram_re    = head_sel != NoNode;
        ram_raddr = word_of({2'b0, head_sel});
      end
      S_A_HDR: begin
        size_d    = rd_size;
        ram_re    = a_ok;
        ram_raddr = word_of({2'b0, cur_q}) + AW'(1);
      end
      S_A_LINK: begin
        heads_d[lid_q] = ram_rdata[15:0];
        ft_d      = ft_q - {1'b0, size_q};
        ram_we    = 1'b1;
        ram_waddr = word_of({2'b0, cur_q});
        ram_wdata = {16'd0, cls_q ? want_q[15:0] : size_q};
        res_d     = cur_q + 16'd4;
      end
      S_A_CARVE: begin
        if (carve_oom) begin
          stat_d = ST_OUT_OF_MEM;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = word_of({1'b0, hw_q});
          ram_wdata = {16'd0, want_q[15:0]};
          res_d     = hw_q[15:0] + 16'd4;
          hw_d      = carve_end[16:0];
        end
      end
      S_F_CHK: begin
        if (f_bad) begin
          stat_d = ST_IGNORED;
        end else begin
          cur_d     = addr_q - 16'd4;
          ram_re    = 1'b1;
          ram_raddr = word_of({2'b0, addr_q - 16'd4});
        end
      end
      S_F_HDR: begin
        if (rd_free) begin
          stat_d = ST_DOUBLE_FREE;
        end else begin
          size_d = rd_size;
          lid_d  = list_of(rd_size);
        end
      end
      S_P_HDR: begin
        ram_we    = 1'b1;
        ram_waddr = word_of({2'b0, cur_q});
        ram_wdata = {15'd0, 1'b1, size_q};
      end
      S_P_LINK: begin
        ram_we         = 1'b1;
        ram_waddr      = word_of({2'b0, cur_q}) + AW'(1);
        ram_wdata      = {16'd0, head_sel};
        heads_d[lid_q] = cur_q;
        ft_d           = (op_q == OP_FREE) ? ft_q + {1'b0, size_q} : ft_q + 17'd4;
      end
      S_R_TEST: begin
        ram_re    = pos_q < {1'b0, hw_q};
        ram_raddr = word_of(pos_q);
      end
      S_R_HDR1: begin
        sp_d      = rd_size;
        nx_d      = r_nxt;
        ram_re    = r_go2;
        ram_raddr = word_of(r_nxt);
        if (!r_go2) begin
          pos_d = r_nxt;
        end
      end
      S_R_HDR2: begin
        if (r_merge) begin
          sn_d     = rd_size;
          phase_d  = 1'b0;
          target_d = pos_q[15:0];
          lid_d    = list_of(sp_q);
        end else begin
          pos_d = nx_q;
        end
      end
      S_RM_START: begin
        cur_d    = head_sel;
        prev_v_d = 1'b0;
        cnt_d    = '0;
      end
      S_RM_TEST: begin
        ram_re    = !rm_stop;
        ram_raddr = word_of({2'b0, cur_q}) + AW'(1);
      end
      S_RM_LINK: begin
        if (rm_hit) begin
          if (!prev_v_q) begin
            heads_d[lid_q] = ram_rdata[15:0];
          end else begin
            ram_we    = 1'b1;
            ram_waddr = word_of({2'b0, prev_q}) + AW'(1);
            ram_wdata = {16'd0, ram_rdata[15:0]};
          end
        end else begin
          prev_d   = cur_q;
          prev_v_d = 1'b1;
          cur_d    = ram_rdata[15:0];
          cnt_d    = cnt_q + (AW+1)'(1);
        end
      end
      S_RM_END: begin
        if (!phase_q) begin
          phase_d  = 1'b1;
          target_d = nx_q[15:0];
          lid_d    = list_of(sn_q);
        end else begin
          size_d = sp_q + 16'd4 + sn_q;
          cur_d  = pos_q[15:0];
          lid_d  = list_of(sp_q + 16'd4 + sn_q);
        end
      end
      S_DONE: begin
        if (can_load) begin
          out_v_d    = 1'b1;
          out_addr_d = res_q;
          out_stat_d = stat_q;
          out_used_d = hw_q;
          out_free_d = ft_q;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      limit_q <= 17'd65536;
      hw_q    <= '0;
      ft_q    <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i <= CLASS_COUNT; i++) begin
        heads_q[i] <= NoNode;
      end
    end else begin
      st_q    <= st_d;
      limit_q <= limit_d;
      hw_q    <= hw_d;
      ft_q    <= ft_d;
      out_v_q <= out_v_d;
      heads_q <= heads_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    want_q     <= want_d;
    lid_q      <= lid_d;
    cls_q      <= cls_d;
    addr_q     <= addr_d;
    cur_q      <= cur_d;
    size_q     <= size_d;
    pos_q      <= pos_d;
    nx_q       <= nx_d;
    sp_q       <= sp_d;
    sn_q       <= sn_d;
    prev_q     <= prev_d;
    prev_v_q   <= prev_v_d;
    cnt_q      <= cnt_d;
    phase_q    <= phase_d;
    target_q   <= target_d;
    res_q      <= res_d;
    stat_q     <= stat_d;
    out_addr_q <= out_addr_d;
    out_stat_q <= out_stat_d;
    out_used_q <= out_used_d;
    out_free_q <= out_free_d;
  end

  assign req_i.ready               = st_q == S_IDLE;
  assign rsp_o.valid               = out_v_q;
  assign rsp_o.payload_address_res = out_addr_q;
  assign rsp_o.status              = out_stat_q;
  assign rsp_o.used_bytes          = out_used_q;
  assign rsp_o.free_bytes          = out_free_q;

endmodule

// ----- sv/scba_checker.sv -----
// Checker: port-level assertions for the allocator, bound to the top level.
`timescale 1ns / 1ps
module scba_checker
  import scba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_addr_i,
  input logic [1:0]  out_status_i,
  input logic [16:0] out_used_i
);

  // Requests are handled one at a time: after a beat is taken the port closes.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while the previous one is still in work");

  // Only a granted allocation carries an address.
  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_addr_i == 16'd0)
    else $error("address reported with a non-ok status");

  // A stalled result holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i) &&
    $stable(out_status_i) && $stable(out_used_i))
    else $error("result changed while stalled");

endmodule

bind size_class_block_allocator scba_checker u_scba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .out_addr_i   (rsp_o.payload_address_res),
  .out_status_i (rsp_o.status),
  .out_used_i   (rsp_o.used_bytes)
);

// ----- dv/tb_top.sv -----
// Testbench: predicts and checks every allocator result under random stalls and limits.
`timescale 1ns / 1ps
module tb_top;
  import scba_pkg::*;

  // The run normally needs far fewer cycles. Reclaim can walk long free lists, so the
  // bound is left wide.
  localparam int unsigned CycleLimit = 8_000_000;
  localparam int unsigned PoolWords  = 16384;
  localparam int unsigned Classes    = 10;
  localparam int unsigned MiscList   = Classes;   // index of the odd-size list

  // How the free address of an item is chosen when the driver presents it.
  typedef enum int {
    PICK_NONE,   // use the address stored in the item
    PICK_LAST,   // payload granted most recently
    PICK_PREV,   // payload granted just before that
    PICK_ANY,    // any payload ever granted
    PICK_BAD     // an address the block must ignore
  } pick_e;

  typedef struct {
    op_e         op;
    logic [15:0] req_bytes;
    logic [15:0] addr;
    pick_e       pick;
  } item_t;

  typedef struct {
    logic [15:0] addr;
    status_e     status;
    logic [16:0] used;
    logic [16:0] freed;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  scba_req_if req_if ();
  scba_rsp_if rsp_if ();

  size_class_block_allocator DUT (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req_if.sink),
    .rsp_o   (rsp_if.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Shadow allocator. Its state moves on each accepted request beat, in beat order.
  // ---------------------------------------------------------------------------------
  logic [31:0] shadow_pool [PoolWords];
  logic [15:0] list_head [Classes + 1];   // class lists, then the odd-size list
  int unsigned carve_mark;                // high-water mark in bytes
  logic [16:0] free_sum;
  logic [16:0] limit_reg;
  logic [15:0] granted [$];               // every payload offset ever handed out

  result_t     expected_results [$];
  item_t       pending_items [$];
  int unsigned errors = 0;
  int unsigned op_seen [4];
  int unsigned status_seen [4];

  function automatic int unsigned word_of(int unsigned hdr);
    return (hdr >> 2) % PoolWords;
  endfunction

  function automatic int unsigned blk_size(int unsigned hdr);
    return shadow_pool[word_of(hdr)][15:0];
  endfunction

  function automatic bit blk_free(int unsigned hdr);
    return shadow_pool[word_of(hdr)][16];
  endfunction

  function automatic void put_header(int unsigned hdr, int unsigned sz, bit fr);
    shadow_pool[word_of(hdr)] = {15'd0, fr, sz[15:0]};
  endfunction

  function automatic int unsigned next_of(int unsigned hdr);
    return shadow_pool[(word_of(hdr) + 1) % PoolWords][15:0];
  endfunction

  function automatic void put_next(int unsigned hdr, int unsigned nxt);
    shadow_pool[(word_of(hdr) + 1) % PoolWords] = {16'd0, nxt[15:0]};
  endfunction

  // Odd sizes share one list; a power-of-two size in range has a list of its own.
  function automatic int unsigned list_of(int unsigned sz);
    for (int i = 0; i < Classes; i++) begin
      if ((8 << i) == sz) return i;
    end
    return MiscList;
  endfunction

  function automatic void push_free(int unsigned li, int unsigned hdr);
    put_header(hdr, blk_size(hdr), 1'b1);
    put_next(hdr, list_head[li]);
    list_head[li] = hdr[15:0];
  endfunction

  // Unlinks one node; a damaged list is walked no further than the pool has words.
  function automatic void unlink(int unsigned li, int unsigned hdr);
    int unsigned cur;
    int unsigned prev;
    int unsigned nxt;
    cur  = list_head[li];
    prev = NoNode;
    for (int n = 0; n < PoolWords && cur != NoNode; n++) begin
      nxt = next_of(cur);
      if (cur == hdr) begin
        if (prev == NoNode) list_head[li] = nxt[15:0];
        else put_next(prev, nxt);
        return;
      end
      prev = cur;
      cur  = nxt;
    end
  endfunction

  function automatic int unsigned rounded_size(int unsigned want);
    if (want < 8) want = 8;
    for (int i = 0; i < Classes; i++) begin
      if (want <= (8 << i)) return 8 << i;
    end
    return (want + 3) & ~32'd3;
  endfunction

  // Walks the carved area and folds each free block into its free predecessor, as long
  // as the follower lies wholly below the high-water mark.
  function automatic void merge_free_runs();
    int unsigned pos;
    int unsigned nxt;
    int unsigned joined;
    pos = 0;
    while (pos < carve_mark) begin
      nxt = pos + HeaderBytes + blk_size(pos);
      if (blk_free(pos) && nxt < carve_mark && blk_free(nxt) &&
          nxt + HeaderBytes + blk_size(nxt) <= carve_mark) begin
        joined = blk_size(pos) + HeaderBytes + blk_size(nxt);
        unlink(list_of(blk_size(pos)), pos);
        unlink(list_of(blk_size(nxt)), nxt);
        put_header(pos, joined, 1'b1);
        push_free(list_of(joined), pos);
        free_sum = free_sum + 17'(HeaderBytes);
      end else begin
        pos = nxt;
      end
    end
  endfunction

  function automatic result_t predict_outcome(item_t it);
    result_t     r;
    int unsigned want;
    int unsigned lim;
    int unsigned li;
    int unsigned hd;
    int unsigned old;
    int unsigned a;
    r.addr   = '0;
    r.status = ST_OK;
    case (it.op)
      OP_ALLOC: begin
        want = rounded_size(it.req_bytes);
        lim  = (limit_reg < 17'd65536) ? limit_reg : 65536;
        li   = list_of(want);
        hd   = list_head[li];
        // An odd-size block is reused only when it is large enough; it keeps its size.
        if (hd != NoNode && (li != MiscList || blk_size(hd) >= want)) begin
          old = blk_size(hd);
          list_head[li] = 16'(next_of(hd));
          free_sum = free_sum - 17'(old);
          put_header(hd, (li != MiscList) ? want : old, 1'b0);
          r.addr = 16'(hd + HeaderBytes);
        end else if (carve_mark + HeaderBytes + want > lim) begin
          r.status = ST_OUT_OF_MEM;
        end else begin
          put_header(carve_mark, want, 1'b0);
          r.addr = 16'(carve_mark + HeaderBytes);
          carve_mark += HeaderBytes + want;
        end
        if (r.status == ST_OK) granted.push_back(r.addr);
      end
      OP_FREE: begin
        a = it.addr;
        if (a < HeaderBytes || a[1:0] != 2'b00 || a - HeaderBytes >= carve_mark) begin
          r.status = ST_IGNORED;
        end else if (blk_free(a - HeaderBytes)) begin
          r.status = ST_DOUBLE_FREE;
        end else begin
          old = blk_size(a - HeaderBytes);
          push_free(list_of(old), a - HeaderBytes);
          free_sum = free_sum + 17'(old);
        end
      end
      OP_RECLAIM: merge_free_runs();
      default: ;
    endcase
    r.used  = 17'(carve_mark);
    r.freed = free_sum;
    return r;
  endfunction

  function automatic void clear_shadow();
    foreach (list_head[i]) list_head[i] = NoNode;
    carve_mark = 0;
    free_sum   = '0;
    limit_reg  = 17'd65536;
  endfunction

  // ---------------------------------------------------------------------------------
  // Request driver. Inputs move on the falling edge; acceptance is seen on the rising
  // edge, where the shadow allocator is advanced.
  // ---------------------------------------------------------------------------------
  bit          idle_enable = 1'b0;
  bit          req_beat = 1'b0;
  int unsigned req_gap = 0;
  item_t       on_wire;

  function automatic logic [15:0] resolve_addr(item_t it);
    logic [15:0] a;
    case (it.pick)
      PICK_LAST: return granted.size() ? granted[$] : 16'd0;
      PICK_PREV: return granted.size() > 1 ? granted[granted.size() - 2] : 16'd0;
      PICK_ANY:  return granted.size() ? granted[$urandom_range(0, granted.size() - 1)]
                                       : 16'd0;
      PICK_BAD: begin
        a = 16'($urandom);
        // Aligned offsets inside the carved area could land on payload words, so those
        // are pushed out of line to keep the address one that is ignored.
        if (a[1:0] == 2'b00 && 32'(a) < carve_mark + HeaderBytes)
          a[1:0] = 2'($urandom_range(1, 3));
        return a;
      end
      default:   return it.addr;
    endcase
  endfunction

  always @(negedge clk) begin
    logic next_valid;
    if (rst_n) begin
      next_valid = req_if.valid && !req_beat;
      if (!next_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending_items.size() > 0) begin
          on_wire      = pending_items.pop_front();
          on_wire.addr = resolve_addr(on_wire);
          req_if.opcode          <= on_wire.op;
          req_if.request_bytes   <= on_wire.req_bytes;
          req_if.payload_address <= on_wire.addr;
          next_valid = 1'b1;
          req_gap = idle_enable ? $urandom_range(0, 9) : 0;
        end
      end
      req_if.valid <= next_valid;
    end
  end

  always @(posedge clk) begin
    req_beat = req_if.valid && req_if.ready;
    if (req_beat) begin
      op_seen[on_wire.op]++;
      expected_results.push_back(predict_outcome(on_wire));
    end
  end

  // ---------------------------------------------------------------------------------
  // Result monitor with its own random stalls and an optional long hold-off.
  // ---------------------------------------------------------------------------------
  bit          hold_off = 1'b0;
  int unsigned rsp_stall = 0;
  int unsigned results_seen = 0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("tb_top: result %0d %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
    errors++;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off) begin
        rsp_if.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      results_seen++;
      status_seen[rsp_if.status]++;
      if (expected_results.size() == 0) begin
        report_mismatch("arrived unasked, status", rsp_if.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (rsp_if.payload_address_res !== want.addr)
          report_mismatch("address", rsp_if.payload_address_res, want.addr);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.used_bytes !== want.used)
          report_mismatch("used bytes", rsp_if.used_bytes, want.used);
        if (rsp_if.free_bytes !== want.freed)
          report_mismatch("free bytes", rsp_if.free_bytes, want.freed);
      end
      rsp_stall = idle_enable ? $urandom_range(0, 9) : 0;
    end
  end

  // Watchdog.
  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_top: watchdog expired with %0d results outstanding",
               expected_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  // The receiver goes deaf for a long stretch while the sender keeps offering beats,
  // so the output register fills and the request side backs up.
  initial begin
    wait (results_seen >= 150);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    @(negedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------------
  // Stimulus and configuration.
  // ---------------------------------------------------------------------------------
  function automatic item_t mk(op_e op, int unsigned bytes, int unsigned addr, pick_e p);
    item_t it;
    it.op        = op;
    it.req_bytes = bytes[15:0];
    it.addr      = addr[15:0];
    it.pick      = p;
    return it;
  endfunction

  function automatic item_t random_item();
    int unsigned r;
    int unsigned s;
    int unsigned sz;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      s = $urandom_range(0, 99);
      if (s < 40) sz = $urandom_range(0, 64);
      else if (s < 70) sz = $urandom_range(65, 600);
      else if (s < 85) sz = 8 << $urandom_range(0, Classes - 1);
      else if (s < 96) sz = $urandom_range(601, 5000);
      else sz = $urandom_range(5001, 65535);
      return mk(OP_ALLOC, sz, 0, PICK_NONE);
    end
    if (r < 90) begin
      s = $urandom_range(0, 99);
      if (s < 75) return mk(OP_FREE, $urandom, 0, PICK_ANY);
      if (s < 87) return mk(OP_FREE, $urandom, 0, PICK_LAST);
      if (s < 97) return mk(OP_FREE, $urandom, 0, PICK_BAD);
      return mk(OP_FREE, $urandom, 0, PICK_NONE);
    end
    if (r < 97) return mk(OP_RECLAIM, $urandom, $urandom, PICK_NONE);
    return mk(OP_NONE, $urandom, $urandom, PICK_NONE);
  endfunction

  // A zero free address in the random mix is the null case, so keep it null.
  task automatic queue_random(int unsigned n);
    item_t it;
    repeat (n) begin
      it = random_item();
      if (it.op == OP_FREE && it.pick == PICK_NONE) it.addr = '0;
      // Refill lazily so that picks of granted payloads see recent grants.
      while (pending_items.size() > 3) @(posedge clk);
      pending_items.push_back(it);
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || req_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic apb_write(logic [16:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {15'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_reg = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    psel    <= 1'b1;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[16:0] !== value) report_mismatch("limit readback", prdata[16:0], value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    req_if.valid           = 1'b0;
    req_if.opcode          = OP_NONE;
    req_if.request_bytes   = '0;
    req_if.payload_address = '0;
    rsp_if.ready           = 1'b0;
    clear_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: size rounding, class edges, odd sizes, the oversized
    // request, null and malformed frees, double free, odd-size reuse in both
    // directions, the unused opcode and a merge of two neighbours.
    pending_items.push_back(mk(OP_ALLOC, 0, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 8, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 9, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 2048, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 4096, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 4097, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 65535, 0, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 0, 0, PICK_LAST));
    pending_items.push_back(mk(OP_FREE, 0, 0, PICK_LAST));
    pending_items.push_back(mk(OP_ALLOC, 5000, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 4098, 0, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 16'hFFFF, 0, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 0, 6, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 0, 2, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 0, 16'hFFFC, PICK_NONE));
    pending_items.push_back(mk(OP_NONE, 16'hFFFF, 16'hFFFF, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 16, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 16, 0, PICK_NONE));
    pending_items.push_back(mk(OP_FREE, 0, 0, PICK_LAST));
    pending_items.push_back(mk(OP_FREE, 0, 0, PICK_PREV));
    pending_items.push_back(mk(OP_RECLAIM, 0, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 36, 0, PICK_NONE));
    pending_items.push_back(mk(OP_ALLOC, 8, 0, PICK_NONE));
    drain();

    // Tightest limit: carving is refused, reuse of freed blocks still works.
    idle_enable = 1'b1;
    apb_write(17'd256);
    queue_random(100);
    drain();

    // Full pool with idling on both sides; the long receiver hold-off falls here.
    apb_write(17'd65536);
    queue_random(400);
    drain();

    // Random limit, then back-to-back traffic with no idling at all.
    apb_write(17'($urandom_range(256, 65536)));
    queue_random(130);
    drain();
    idle_enable = 1'b0;
    apb_write(17'd65536);
    queue_random(100);
    drain();

    $display("tb_top: %0d results; alloc %0d free %0d reclaim %0d unused %0d",
             results_seen, op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_RECLAIM],
             op_seen[OP_NONE]);
    $display("tb_top: ok %0d, out of memory %0d, double free %0d, ignored %0d",
             status_seen[ST_OK], status_seen[ST_OUT_OF_MEM], status_seen[ST_DOUBLE_FREE],
             status_seen[ST_IGNORED]);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
